### rtl/ptab_pkg.sv
// Shared types and codes for the prefix tree acceptor builder.
// Request and result structs, label and outcome codes, controller states.
// No dependencies.
`default_nettype none

package ptab_pkg;

  localparam int DEF_MAX_NODES   = 256;
  localparam int DEF_SYMBOL_BITS = 8;

  localparam int SYMBOL_W  = 8;
  localparam int LABEL_W   = 2;
  localparam int NODE_W    = 8;
  localparam int COUNT_W   = 9;
  localparam int OUTCOME_W = 3;

  // node labels
  localparam logic [LABEL_W-1:0] LBL_REJ = 2'd0;
  localparam logic [LABEL_W-1:0] LBL_ACC = 2'd1;
  localparam logic [LABEL_W-1:0] LBL_UNK = 2'd2;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_FOLLOWED = 3'd0,
    OUT_CREATED  = 3'd1,
    OUT_SKIPPED  = 3'd2,
    OUT_CONFLICT = 3'd3,
    OUT_FULL     = 3'd4,
    OUT_ROOT     = 3'd5
  } outcome_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_LABEL,
    ST_ALLOC
  } state_t;

  typedef struct packed {
    logic [SYMBOL_W-1:0] symbol;
    logic                first_symbol;
    logic                last_symbol;
    logic [LABEL_W-1:0]  label;
    logic                empty_string;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0]    node;
    logic [COUNT_W-1:0]   node_count;
    logic [OUTCOME_W-1:0] outcome;
  } out_t;

endpackage

`default_nettype wire

### rtl/ptab_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port,
// read data registered. No dependencies.
`default_nettype none

module ptab_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/prefix_tree_acceptor_builder.sv
// Flow: a started request is decoded in ST_LOOK, where follow, skip, full and
// root requests end; node creation goes on to ST_ALLOC and a last symbol over an
// existing edge to ST_LABEL. A new start is taken only in ST_IDLE, in the cycle
// its predecessor's result is shown. The node memory is read twice in
// dependent cycles (row of the current node, then label of the target).
// Reset: one cycle after rst writes the root entry; busy is high meanwhile.
// The receiver cannot stall: each result is shown for one cycle only.
`default_nettype none

module prefix_tree_acceptor_builder #(
  parameter int MAX_NODES   = ptab_pkg::DEF_MAX_NODES,
  parameter int SYMBOL_BITS = ptab_pkg::DEF_SYMBOL_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire ptab_pkg::in_t item,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  output logic               result_valid,
  output ptab_pkg::out_t     result
);

  import ptab_pkg::*;

  localparam int NW       = $clog2(MAX_NODES);
  localparam int CW       = $clog2(MAX_NODES + 1);
  localparam int SYM_CNT  = 1 << SYMBOL_BITS;
  localparam int EDGES    = MAX_NODES * SYM_CNT;
  localparam int EAW      = NW + SYMBOL_BITS;
  localparam int NODE_WD  = SYM_CNT + LABEL_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(MAX_NODES);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  // control state
  state_t          state, state_next;
  logic [NW-1:0]   walk_node, walk_node_next;
  logic [CW-1:0]   nodes_used, nodes_used_next;
  logic            root_labelled, root_labelled_next;
  logic            include_negative;

  // request context
  in_t             req;
  logic [NW-1:0]   cur;
  logic [NW-1:0]   tgt, tgt_next;

  // memory ports
  logic               nd_we;
  logic [NW-1:0]      nd_waddr, nd_raddr;
  logic [NODE_WD-1:0] nd_wdata, nd_rdata;
  logic               ed_we;
  logic [EAW-1:0]     ed_waddr, ed_raddr;
  logic [NW-1:0]      ed_wdata, ed_rdata;

  // decode helpers
  logic [NW-1:0]           cur_in;
  logic [SYMBOL_BITS-1:0]  sym_in, sym;
  logic [SYM_CNT-1:0]      row, row_set;
  logic [LABEL_W-1:0]      have, want;
  logic                    accepting;
  logic                    emit;
  logic [NW-1:0]           emit_node;
  outcome_t                emit_outcome;
  logic [NW+NODE_W-1:0]    node_ext;
  logic [CW+COUNT_W-1:0]   count_ext;

  ptab_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_WD)) u_node_mem (
    .clk   (clk),
    .we    (nd_we),
    .waddr (nd_waddr),
    .wdata (nd_wdata),
    .raddr (nd_raddr),
    .rdata (nd_rdata)
  );

  ptab_ram #(.DEPTH(EDGES), .WIDTH(NW)) u_edge_mem (
    .clk   (clk),
    .we    (ed_we),
    .waddr (ed_waddr),
    .wdata (ed_wdata),
    .raddr (ed_raddr),
    .rdata (ed_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign cur_in    = item.first_symbol ? '0 : walk_node;
  assign sym_in    = item.symbol[SYMBOL_BITS-1:0];
  assign sym       = req.symbol[SYMBOL_BITS-1:0];
  assign accepting = (req.label == LBL_ACC);
  assign want      = accepting ? LBL_ACC : LBL_REJ;
  assign row       = nd_rdata[NODE_WD-1:LABEL_W];
  assign have      = nd_rdata[LABEL_W-1:0];

  always_comb begin
    row_set      = row;
    row_set[sym] = 1'b1;
  end

  always_comb begin
    state_next         = state;
    walk_node_next     = walk_node;
    nodes_used_next    = nodes_used;
    root_labelled_next = root_labelled;
    tgt_next           = tgt;
    nd_we              = 1'b0;
    nd_waddr           = '0;
    nd_wdata           = '0;
    nd_raddr           = ed_rdata;
    ed_we              = 1'b0;
    ed_waddr           = {cur, sym};
    ed_wdata           = nodes_used[NW-1:0];
    ed_raddr           = {cur_in, sym_in};
    emit               = 1'b0;
    emit_node          = '0;
    emit_outcome       = OUT_SKIPPED;

    unique case (state)
      ST_INIT: begin
        // root entry: no edges, label unknown
        nd_we      = 1'b1;
        nd_waddr   = '0;
        nd_wdata   = {{SYM_CNT{1'b0}}, LBL_UNK};
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        nd_raddr = item.empty_string ? '0 : cur_in;
        if (start) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        priority if (req.empty_string) begin
          walk_node_next = '0;
          emit           = 1'b1;
          state_next     = ST_IDLE;
          if (!root_labelled) begin
            nd_we              = 1'b1;
            nd_waddr           = '0;
            nd_wdata           = {row, want};
            root_labelled_next = 1'b1;
            emit_outcome       = OUT_ROOT;
          end
        end else if (!include_negative && !accepting) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end else if (row[sym]) begin
          walk_node_next = ed_rdata;
          tgt_next       = ed_rdata;
          if (req.last_symbol) begin
            // fetch the target's label and row
            state_next = ST_LABEL;
          end else begin
            emit         = 1'b1;
            emit_node    = ed_rdata;
            emit_outcome = OUT_FOLLOWED;
            state_next   = ST_IDLE;
          end
        end else if (nodes_used == FULL_CNT) begin
          walk_node_next = cur;
          emit           = 1'b1;
          emit_node      = cur;
          emit_outcome   = OUT_FULL;
          state_next     = ST_IDLE;
        end else begin
          // link the new edge now, initialize the new node next cycle
          nd_we           = 1'b1;
          nd_waddr        = cur;
          nd_wdata        = {row_set, have};
          ed_we           = 1'b1;
          walk_node_next  = nodes_used[NW-1:0];
          tgt_next        = nodes_used[NW-1:0];
          nodes_used_next = nodes_used + ONE_CNT;
          state_next      = ST_ALLOC;
        end
      end
      ST_LABEL: begin
        emit       = 1'b1;
        emit_node  = tgt;
        state_next = ST_IDLE;
        if ((want == LBL_ACC && have == LBL_REJ) ||
            (want == LBL_REJ && have == LBL_ACC)) begin
          emit_outcome = OUT_CONFLICT;
        end else begin
          nd_we        = 1'b1;
          nd_waddr     = tgt;
          nd_wdata     = {row, want};
          emit_outcome = OUT_FOLLOWED;
        end
      end
      ST_ALLOC: begin
        nd_we        = 1'b1;
        nd_waddr     = tgt;
        nd_wdata     = {{SYM_CNT{1'b0}}, (req.last_symbol ? want : LBL_UNK)};
        emit         = 1'b1;
        emit_node    = tgt;
        emit_outcome = OUT_CREATED;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  assign node_ext  = {{NODE_W{1'b0}}, emit_node};
  assign count_ext = {{COUNT_W{1'b0}}, nodes_used};

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_INIT;
      walk_node        <= '0;
      nodes_used       <= ONE_CNT;
      root_labelled    <= 1'b0;
      include_negative <= 1'b0;
      result_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      walk_node     <= walk_node_next;
      nodes_used    <= nodes_used_next;
      root_labelled <= root_labelled_next;
      result_valid  <= emit;
      if (cfg_we) begin
        include_negative <= cfg_wdata;
      end
    end
  end

  // request context and result payload
  always_ff @(posedge clk) begin
    tgt <= tgt_next;
    if (state == ST_IDLE && start) begin
      req <= item;
      cur <= cur_in;
    end
    if (emit) begin
      result.node       <= node_ext[NODE_W-1:0];
      result.node_count <= count_ext[COUNT_W-1:0];
      result.outcome    <= emit_outcome;
    end
  end

endmodule

`default_nettype wire
